// File: rtl/core/pbmr_pkg.sv
// Shared types, constants and codes for the power bar meter renderer.
// Depends on nothing; every other file of the block imports it.
package pbmr_pkg;

    localparam int BAR_PIXELS = 9;
    localparam int PIX_W      = 4;
    localparam int LVL_W      = $clog2(BAR_PIXELS + 1);
    localparam int PWR_W      = 16;
    localparam int LVL_CFG_W  = 10;
    localparam int GLT_W      = 15;
    localparam int COL_W      = 8;
    localparam int DVD_W      = 24;
    localparam int DIV_STEPS  = 8;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [LVL_CFG_W-1:0] MIN_LEVEL_RST    = 10'd50;
    localparam logic [LVL_CFG_W-1:0] SLEW_STEP_RST    = 10'd5;
    localparam logic [GLT_W-1:0]     GLITCH_LIMIT_RST = 15'd50;
    localparam logic [LVL_CFG_W-1:0] DIM_FLOOR_RST    = 10'd10;

    localparam logic [COL_W-1:0] FULL_ON   = 8'd255;
    localparam logic [COL_W-1:0] DIM_LEVEL = 8'd8;

    typedef enum logic [1:0] {
        REG_MIN_LEVEL    = 2'd0,
        REG_SLEW_STEP    = 2'd1,
        REG_GLITCH_LIMIT = 2'd2,
        REG_DIM_FLOOR    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        RND_IDLE,
        RND_LEVEL,
        RND_LOAD,
        RND_RUN
    } t_rnd_state;

    typedef struct packed {
        logic                    mode;
        logic signed [PWR_W-1:0] watt;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_index;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic             frame_end;
    } t_out_item;

    typedef struct packed {
        logic                    push;
        logic signed [PWR_W-1:0] power;
    } t_q_push;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [PWR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [COL_W-1:0] quot;
    } t_div_stat;

endpackage

// File: rtl/core/power_bar_meter_renderer_core.sv
// Top level of the power bar meter renderer: APB registers, front end, queue, renderer.
// Depends on pbmr_pkg, pbmr_front, pbmr_queue and pbmr_render.
//
// Power samples and display ticks enter on the input channel. A sample
// updates the stored power (a zero sample is dropped while the stored
// magnitude is above glitch_limit). In the front end a tick slews the shown
// power by at most slew_step and, if the shown value differed from the
// stored one, posts the new shown value to a two-entry queue. The renderer
// drains that queue and writes nine pixels, bottom first, one per cycle
// through an output register while the output is ready and no fade result
// is awaited; the eight-step fade divider runs while the fully lit pixels
// below the faded one are sent. The front end only stalls when the queue is full.
// Registers sit at byte addresses 0 (min_level), 4 (slew_step),
// 8 (glitch_limit) and 12 (dim_floor); write them only while the block is idle.
module power_bar_meter_renderer_core
    import pbmr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input items
    input  logic              i_in_valid,
    input  t_in_item          i_in_item,
    output logic              o_in_ready,
    // pixel results
    output logic              o_out_valid,
    output t_out_item         o_out_item,
    input  logic              i_out_ready,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [LVL_CFG_W-1:0] r_min_level;
    logic [LVL_CFG_W-1:0] r_slew_step;
    logic [GLT_W-1:0]     r_glitch_limit;
    logic [LVL_CFG_W-1:0] r_dim_floor;

    logic                    cfg_wr;
    t_reg_idx                reg_idx;
    t_q_push                 q_push;
    logic                    q_pop, q_valid, q_full;
    logic signed [PWR_W-1:0] q_power;
    logic                    rnd_busy;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    // register write: take the low bits of the data word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_level    <= MIN_LEVEL_RST;
            r_slew_step    <= SLEW_STEP_RST;
            r_glitch_limit <= GLITCH_LIMIT_RST;
            r_dim_floor    <= DIM_FLOOR_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MIN_LEVEL:    r_min_level    <= pwdata[LVL_CFG_W-1:0];
                REG_SLEW_STEP:    r_slew_step    <= pwdata[LVL_CFG_W-1:0];
                REG_GLITCH_LIMIT: r_glitch_limit <= pwdata[GLT_W-1:0];
                REG_DIM_FLOOR:    r_dim_floor    <= pwdata[LVL_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (reg_idx)
            REG_MIN_LEVEL:    prdata = APB_DW'(r_min_level);
            REG_SLEW_STEP:    prdata = APB_DW'(r_slew_step);
            REG_GLITCH_LIMIT: prdata = APB_DW'(r_glitch_limit);
            REG_DIM_FLOOR:    prdata = APB_DW'(r_dim_floor);
            default:          prdata = '0;
        endcase
    end

    // front end: classify items, hold stored and shown power
    pbmr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_item      (i_in_item),
        .o_in_ready     (o_in_ready),
        .i_slew_step    (r_slew_step),
        .i_glitch_limit (r_glitch_limit),
        .i_q_full       (q_full),
        .o_push         (q_push)
    );

    // decouple the front end from frame output
    pbmr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_power (q_power),
        .o_full  (q_full)
    );

    // back end: draw one frame per queued value
    pbmr_render u_render (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_power   (q_power),
        .o_q_pop     (q_pop),
        .i_min_level (r_min_level),
        .i_dim_floor (r_dim_floor),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_ready (i_out_ready),
        .o_busy      (rnd_busy)
    );

    // frame end marks exactly the top pixel
    a_frame_end_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.frame_end ==
                         (o_out_item.pixel_index == PIX_W'(BAR_PIXELS - 1))))
        else $error("frame_end does not match the top pixel");

    // the front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push.push |-> !q_full)
        else $error("render request pushed into a full queue");

    // a frame in flight keeps the renderer busy until its top pixel
    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_item.frame_end) |=> rnd_busy)
        else $error("renderer went idle in the middle of a frame");

endmodule

// File: rtl/core/pbmr_front.sv
// Front end: takes input items, keeps the stored and shown power, slews on ticks.
// Depends on pbmr_pkg; queues a render request whenever the shown value changes.
module pbmr_front
    import pbmr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_item,
    output logic                 o_in_ready,
    input  logic [LVL_CFG_W-1:0] i_slew_step,
    input  logic [GLT_W-1:0]     i_glitch_limit,
    input  logic                 i_q_full,
    output t_q_push              o_push
);

    logic signed [PWR_W-1:0] r_stored, n_stored;
    logic signed [PWR_W-1:0] r_shown,  n_shown;

    logic                    accept;
    logic [PWR_W:0]          stored_mag;
    logic signed [PWR_W+1:0] shown_x, stored_x, step_x;
    logic                    changed;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        stored_mag = r_stored[PWR_W-1] ? (PWR_W+1)'(-{r_stored[PWR_W-1], r_stored})
                                       : {1'b0, r_stored};
        shown_x    = {{2{r_shown[PWR_W-1]}}, r_shown};
        stored_x   = {{2{r_stored[PWR_W-1]}}, r_stored};
        step_x     = $signed({8'b0, i_slew_step});
        changed    = r_shown != r_stored;
        n_stored   = r_stored;
        n_shown    = r_shown;
        o_push     = '0;

        if (accept) begin
            if (!i_in_item.mode) begin
                // drop a zero sample while a large value is held
                if (!(i_in_item.watt == '0 && stored_mag > {2'b0, i_glitch_limit})) begin
                    n_stored = i_in_item.watt;
                end
            end else if (changed) begin
                if (shown_x + step_x < stored_x) begin
                    n_shown = PWR_W'(shown_x + step_x);
                end else if (shown_x - step_x > stored_x) begin
                    n_shown = PWR_W'(shown_x - step_x);
                end else begin
                    n_shown = r_stored;
                end
                o_push.push  = 1'b1;
                o_push.power = n_shown;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored <= '0;
            r_shown  <= '0;
        end else begin
            r_stored <= n_stored;
            r_shown  <= n_shown;
        end
    end

endmodule

// File: rtl/core/pbmr_queue.sv
// Short request queue between front end and renderer.
// Depends on pbmr_pkg; holds shown power values awaiting a frame.
module pbmr_queue
    import pbmr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_q_push                 i_push,
    input  logic                    i_pop,
    output logic                    o_valid,
    output logic signed [PWR_W-1:0] o_power,
    output logic                    o_full
);

    logic signed [PWR_W-1:0] r_mem [Q_DEPTH];
    logic [Q_AW-1:0]         r_wp, n_wp;
    logic [Q_AW-1:0]         r_rp, n_rp;
    logic [Q_AW:0]           r_cnt, n_cnt;
    logic                    do_push, do_pop;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_power = r_mem[r_rp];

    always_comb begin
        do_push = i_push.push && !o_full;
        do_pop  = i_pop && o_valid;
        n_wp    = do_push ? r_wp + 1'b1 : r_wp;
        n_rp    = do_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt   = r_cnt + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.power;
        end
    end

endmodule

// File: rtl/core/pbmr_div.sv
// Restoring divider for the fade level, one quotient bit per cycle.
// Depends on pbmr_pkg; quotient is known to stay below 256.
module pbmr_div
    import pbmr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_stat o_stat
);

    logic [DVD_W-1:0]  r_rem, n_rem;
    logic [DVD_W-1:0]  r_dsh, n_dsh;
    logic [COL_W-1:0]  r_quot, n_quot;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              ge;

    assign o_stat.done = r_done;
    assign o_stat.quot = r_quot;

    always_comb begin
        ge     = r_rem >= r_dsh;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_req.start) begin
            n_rem  = i_req.dividend;
            n_dsh  = DVD_W'({i_req.divisor, 7'b0});
            n_quot = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = r_rem - r_dsh;
            end
            n_quot = {r_quot[COL_W-2:0], ge};
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

endmodule

// File: rtl/core/pbmr_render.sv
// Back end: turns one shown power value into a frame of bar pixels.
// Depends on pbmr_pkg and pbmr_div; owns the output register.
module pbmr_render
    import pbmr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  logic signed [PWR_W-1:0] i_q_power,
    output logic                    o_q_pop,
    input  logic [LVL_CFG_W-1:0]    i_min_level,
    input  logic [LVL_CFG_W-1:0]    i_dim_floor,
    output logic                    o_out_valid,
    output t_out_item               o_out_item,
    input  logic                    i_out_ready,
    output logic                    o_busy
);

    t_rnd_state       r_state, n_state;
    logic [PWR_W-1:0] r_mag, n_mag;
    logic             r_neg, n_neg;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic             r_dim, n_dim;
    logic [PIX_W-1:0] r_pix, n_pix;
    logic             r_ovalid, n_ovalid;
    t_out_item        r_oitem, n_oitem;

    t_div_req         div_req;
    t_div_stat        div_stat;

    logic [PWR_W-1:0] min_ext, lo, num, den;
    logic [LVL_W-1:0] lvl_cnt, shamt, pix_ext;
    logic             out_free, wait_fade, emit;
    logic [COL_W-1:0] fade_r, fade_g;

    pbmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;
    assign o_busy      = (r_state != RND_IDLE) || r_ovalid;

    // level: first pixel whose threshold the magnitude misses
    always_comb begin
        min_ext = {6'b0, i_min_level};
        lvl_cnt = LVL_W'(BAR_PIXELS);
        for (int k = BAR_PIXELS - 1; k >= 0; k--) begin
            if ((r_mag >> k) < min_ext) begin
                lvl_cnt = LVL_W'(k);
            end
        end
    end

    always_comb begin
        shamt    = r_lvl - 1'b1;
        lo       = min_ext << shamt;
        num      = (r_lvl == '0) ? r_mag : r_mag - lo;
        den      = (r_lvl == '0) ? min_ext : lo;
        pix_ext  = LVL_W'(r_pix);
        fade_r   = r_neg ? '0 : div_stat.quot;
        fade_g   = r_neg ? div_stat.quot : '0;
        out_free = !r_ovalid || i_out_ready;
        wait_fade = (pix_ext == r_lvl) && !r_dim && !div_stat.done;
        emit     = (r_state == RND_RUN) && out_free && !wait_fade;

        div_req.start    = r_state == RND_LOAD;
        div_req.dividend = {num, 8'b0} - {8'b0, num};
        div_req.divisor  = den;

        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_lvl    = r_lvl;
        n_dim    = r_dim;
        n_pix    = r_pix;
        n_ovalid = i_out_ready ? 1'b0 : r_ovalid;
        n_oitem  = r_oitem;
        o_q_pop  = 1'b0;

        case (r_state)
            RND_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_neg   = i_q_power[PWR_W-1];
                    n_mag   = i_q_power[PWR_W-1] ? PWR_W'(-i_q_power) : i_q_power;
                    n_state = RND_LEVEL;
                end
            end
            RND_LEVEL: begin
                n_lvl   = lvl_cnt;
                n_dim   = (lvl_cnt == '0) && (r_mag <= {6'b0, i_dim_floor});
                n_state = RND_LOAD;
            end
            RND_LOAD: begin
                n_pix   = '0;
                n_state = RND_RUN;
            end
            RND_RUN: begin
                if (emit) begin
                    n_ovalid            = 1'b1;
                    n_oitem.pixel_index = r_pix;
                    n_oitem.blue        = '0;
                    n_oitem.frame_end   = r_pix == PIX_W'(BAR_PIXELS - 1);
                    if (pix_ext < r_lvl) begin
                        n_oitem.red   = r_neg ? '0 : FULL_ON;
                        n_oitem.green = r_neg ? FULL_ON : '0;
                    end else if (pix_ext == r_lvl) begin
                        n_oitem.red   = r_dim ? DIM_LEVEL : fade_r;
                        n_oitem.green = r_dim ? DIM_LEVEL : fade_g;
                    end else begin
                        n_oitem.red   = '0;
                        n_oitem.green = '0;
                    end
                    n_pix = r_pix + 1'b1;
                    if (r_pix == PIX_W'(BAR_PIXELS - 1)) begin
                        n_state = RND_IDLE;
                    end
                end
            end
            default: begin
                n_state = RND_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= RND_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_lvl   <= n_lvl;
        r_dim   <= n_dim;
        r_pix   <= n_pix;
        r_oitem <= n_oitem;
    end

endmodule

// File: dv/tb.sv
// Self-checking bench for power_bar_meter_renderer_core: samples and ticks go in, pixels come out.
// Depends on pbmr_pkg and the core RTL; a built-in bar model predicts every pixel of every frame.
module tb
    import pbmr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Settle time after the last pixel of a frame, in cycles.
    localparam int SETTLE_CYCLES = 40;

    // One slot of the stimulus feed: either a request or a marker that makes the
    // sender hold off until every outstanding pixel has arrived.
    typedef struct {
        bit       drain;
        t_in_item item;
    } t_feed_slot;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports (all inputs start at known values)
    // ------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_in_item          i_in_item   = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    t_out_item         o_out_item;
    logic              i_out_ready = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    always #5 i_clk = ~i_clk;

    power_bar_meter_renderer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_ready (i_out_ready),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Bar model: its own copy of the registers and of the two power values
    // ------------------------------------------------------------------
    logic [LVL_CFG_W-1:0]    min_lvl    = MIN_LEVEL_RST;
    logic [LVL_CFG_W-1:0]    slew       = SLEW_STEP_RST;
    logic [GLT_W-1:0]        glitch_lim = GLITCH_LIMIT_RST;
    logic [LVL_CFG_W-1:0]    dim_flr    = DIM_FLOOR_RST;
    logic signed [PWR_W-1:0] stored_pw  = '0;
    logic signed [PWR_W-1:0] shown_pw   = '0;

    t_out_item  pixels_due[$];   // pixels still owed by the block, oldest first
    t_feed_slot feed_q[$];       // requests waiting for the sender

    int  mism_cnt   = 0;
    int  req_taken  = 0;
    bit  no_idle    = 1'b0;      // phase-wide switch: run both sides flat out
    bit  drain_wait = 1'b0;
    bit  rx_hold    = 1'b0;      // long receiver stall, driven by its own process
    int  tx_gap     = 0;
    int  rx_gap     = 0;

    // Draw one frame for the given shown power and queue its nine pixels.
    task automatic bar_render(input logic signed [PWR_W-1:0] pw);
        t_out_item        px [BAR_PIXELS];
        logic [COL_W-1:0] cr;
        logic [COL_W-1:0] cg;
        longint           m;
        longint           lvl;
        longint           lo;
        longint           hi;
        longint           span;
        longint           d;
        int               k;
        cr  = (pw < 0) ? '0 : FULL_ON;
        cg  = (pw < 0) ? FULL_ON : '0;
        // Widen before negating so the most negative sample keeps its magnitude.
        m   = (pw < 0) ? -longint'(pw) : longint'(pw);
        lvl = longint'(min_lvl);
        for (k = 0; k < BAR_PIXELS; k++) begin
            px[k].pixel_index = PIX_W'(k);
            px[k].red         = '0;
            px[k].green       = '0;
            px[k].blue        = '0;
            px[k].frame_end   = (k == BAR_PIXELS - 1);
        end
        if (m < lvl) begin
            // Below the first threshold: dim yellow, or a partial bottom pixel.
            if (m <= longint'(dim_flr)) begin
                px[0].red   = DIM_LEVEL;
                px[0].green = DIM_LEVEL;
            end else begin
                px[0].red   = COL_W'(longint'(cr) * m / lvl);
                px[0].green = COL_W'(longint'(cg) * m / lvl);
            end
        end else begin
            k = 0;
            while (k < BAR_PIXELS && m >= (lvl << k)) begin
                px[k].red   = cr;
                px[k].green = cg;
                k++;
            end
            // Fade the first pixel that is not full, unless the bar is full.
            if (k > 0 && k < BAR_PIXELS) begin
                lo   = lvl << (k - 1);
                hi   = lvl << k;
                span = hi - lo;
                d    = m - lo;
                if (span != 0) begin
                    px[k].red   = COL_W'(longint'(cr) * d / span);
                    px[k].green = COL_W'(longint'(cg) * d / span);
                end
            end
        end
        for (k = 0; k < BAR_PIXELS; k++)
            pixels_due.push_back(px[k]);
    endtask

    // Apply one accepted request to the model state.
    task automatic meter_step(input t_in_item it);
        int mag;
        int sh;
        int sd;
        int st;
        if (it.mode == MODE_SAMPLE) begin
            mag = (stored_pw < 0) ? -int'(stored_pw) : int'(stored_pw);
            // Drop a zero sample as a glitch while the stored magnitude is large.
            if (!(it.watt == 0 && mag > int'(glitch_lim)))
                stored_pw = it.watt;
        end else if (shown_pw != stored_pw) begin
            sh = int'(shown_pw);
            sd = int'(stored_pw);
            st = int'(slew);
            if (sh + st < sd)
                sh = sh + st;
            else if (sh - st > sd)
                sh = sh - st;
            else
                sh = sd;
            shown_pw = PWR_W'(sh);
            bar_render(shown_pw);
        end
    endtask

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued requests, hold each until it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv
        t_feed_slot slot;
        logic       nxt_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                meter_step(i_in_item);
                req_taken++;
                nxt_valid = 1'b0;
                tx_gap    = pick_gap();
            end
            // Fetch the next request only once the current one has gone, so that
            // valid can stay high from one request to the next.
            if (!nxt_valid) begin
                if (drain_wait) begin
                    if (pixels_due.size() == 0)
                        drain_wait = 1'b0;
                end else if (tx_gap > 0) begin
                    tx_gap--;
                end else if (feed_q.size() > 0) begin
                    slot = feed_q.pop_front();
                    if (slot.drain) begin
                        drain_wait = 1'b1;
                    end else begin
                        nxt_valid = 1'b1;
                        i_in_item <= slot.item;
                    end
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each taken pixel against the oldest one owed, pace ready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pixels_due.size() == 0) begin
                    if (mism_cnt < 10)
                        $display("%0t: pixel %0d (%0d,%0d,%0d end %0b) with none owed",
                                 $realtime, o_out_item.pixel_index, o_out_item.red,
                                 o_out_item.green, o_out_item.blue, o_out_item.frame_end);
                    mism_cnt++;
                end else begin
                    want = pixels_due.pop_front();
                    if (o_out_item.pixel_index !== want.pixel_index ||
                        o_out_item.red         !== want.red         ||
                        o_out_item.green       !== want.green       ||
                        o_out_item.blue        !== want.blue        ||
                        o_out_item.frame_end   !== want.frame_end) begin
                        if (mism_cnt < 10)
                            $display("%0t: want px %0d (%0d,%0d,%0d end %0b) got px %0d (%0d,%0d,%0d end %0b)",
                                     $realtime, want.pixel_index, want.red, want.green,
                                     want.blue, want.frame_end, o_out_item.pixel_index,
                                     o_out_item.red, o_out_item.green, o_out_item.blue,
                                     o_out_item.frame_end);
                        mism_cnt++;
                    end
                end
            end
            // Start a fresh gap now and then, so stalls land on any pixel of a frame.
            if (rx_gap > 0)
                rx_gap--;
            else if ($urandom_range(0, 3) == 0)
                rx_gap = pick_gap();
            i_out_ready <= (rx_gap == 0) && !rx_hold;
        end
    end

    // Long receiver stall part way through: the sender keeps offering, so the
    // frame queue fills and the input side must stall.
    initial begin : rx_stall
        int n;
        wait (req_taken >= 150);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        for (n = 0; n < 400; n++)
            @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Fixed limit on the whole run.
    initial begin : watchdog
        #15ms;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_req(input logic mode, input logic signed [PWR_W-1:0] watt);
        t_feed_slot slot;
        slot.drain      = 1'b0;
        slot.item.mode  = mode;
        slot.item.watt  = watt;
        feed_q.push_back(slot);
    endtask

    task automatic queue_drain();
        t_feed_slot slot;
        slot.drain = 1'b1;
        slot.item  = '0;
        feed_q.push_back(slot);
    endtask

    // Wait until every request has gone and every owed pixel has arrived.
    task automatic wait_quiet();
        do
            @(posedge i_clk);
        while (feed_q.size() != 0 || i_in_valid || drain_wait || pixels_due.size() != 0);
    endtask

    // APB write: setup cycle, then access cycle until pready; mirror into the model.
    task automatic reg_write(input t_reg_idx idx, input logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_LEVEL:    min_lvl    = val[LVL_CFG_W-1:0];
            REG_SLEW_STEP:    slew       = val[LVL_CFG_W-1:0];
            REG_GLITCH_LIMIT: glitch_lim = val[GLT_W-1:0];
            REG_DIM_FLOOR:    dim_flr    = val[LVL_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int lvl, input int stp, input int glt, input int dim);
        reg_write(REG_MIN_LEVEL, APB_DW'(lvl));
        reg_write(REG_SLEW_STEP, APB_DW'(stp));
        reg_write(REG_GLITCH_LIMIT, APB_DW'(glt));
        reg_write(REG_DIM_FLOOR, APB_DW'(dim));
    endtask

    // Random request, weighted towards zero, the extremes and the bar thresholds.
    function automatic t_in_item draw_item();
        t_in_item it;
        int       v;
        int       k;
        it.mode = ($urandom_range(0, 99) < 55) ? MODE_TICK : MODE_SAMPLE;
        it.watt = PWR_W'($urandom);
        if (it.mode == MODE_SAMPLE) begin
            case ($urandom_range(0, 9))
                0: it.watt = '0;
                1: it.watt = 16'sh7fff;
                2: it.watt = 16'sh8000;
                3, 4: ;
                5, 6: begin
                    v = $urandom_range(0, 2 * int'(min_lvl) + 16);
                    if ($urandom_range(0, 1))
                        v = -v;
                    it.watt = PWR_W'(v);
                end
                default: begin
                    k = $urandom_range(0, BAR_PIXELS - 1);
                    v = (int'(min_lvl) << k) + $urandom_range(0, 6) - 3;
                    if (v > 32767)
                        v = 32767;
                    if (v < 0)
                        v = 0;
                    if ($urandom_range(0, 1))
                        v = -v;
                    it.watt = PWR_W'(v);
                end
            endcase
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : seq
        t_in_item it;
        int       p;
        int       n;
        int       lvl;
        int       stp;
        int       glt;
        int       dim;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset register values: dim pixel, no-change tick, partial
        // bottom pixel, a zero sample that is kept, slewing down and back.
        queue_req(MODE_SAMPLE, 16'sd3);
        queue_req(MODE_TICK, 16'sd0);
        queue_req(MODE_TICK, -16'sd1);
        queue_req(MODE_SAMPLE, 16'sd20);
        queue_req(MODE_TICK, 16'sd0);
        queue_req(MODE_TICK, 16'sd0);
        queue_req(MODE_SAMPLE, 16'sd0);
        queue_req(MODE_TICK, 16'sd0);
        queue_req(MODE_TICK, 16'sd0);
        queue_req(MODE_TICK, 16'sd0);
        queue_req(MODE_SAMPLE, -16'sd30);
        queue_req(MODE_TICK, 16'sd0);
        queue_drain();
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Directed, extreme registers: full red bar, dropped glitch, most
        // negative sample, and a fade of the third pixel.
        write_all(1, 1023, 0, 0);
        queue_req(MODE_SAMPLE, 16'sh7fff);
        queue_req(MODE_TICK, 16'sh7fff);
        queue_req(MODE_SAMPLE, 16'sd0);
        queue_req(MODE_TICK, 16'sh8000);
        queue_req(MODE_SAMPLE, 16'sh8000);
        queue_req(MODE_TICK, 16'sd0);
        queue_req(MODE_TICK, 16'sd0);
        queue_req(MODE_SAMPLE, 16'sd3);
        queue_req(MODE_TICK, 16'sd0);
        queue_req(MODE_TICK, 16'sd0);
        queue_req(MODE_TICK, 16'sd0);
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Random phases, each with its own register setting.
        for (p = 1; p <= 6; p++) begin
            case (p % 4)
                0:       lvl = 1;
                1:       lvl = 1023;
                2:       lvl = $urandom_range(1, 40);
                default: lvl = $urandom_range(1, 1023);
            endcase
            case (p % 3)
                0:       stp = 1023;
                1:       stp = 1;
                default: stp = $urandom_range(1, 1023);
            endcase
            case (p % 3)
                0:       glt = 0;
                1:       glt = 32767;
                default: glt = $urandom_range(0, 32767);
            endcase
            case (p % 4)
                0:       dim = 1023;
                1:       dim = 0;
                2:       dim = $urandom_range(0, 1023);
                default: dim = $urandom_range(0, 64);
            endcase
            no_idle = (p == 2 || p == 5);
            write_all(lvl, stp, glt, dim);
            for (n = 0; n < 73; n++) begin
                it = draw_item();
                queue_req(it.mode, it.watt);
                // Occasionally let everything drain before carrying on.
                if ($urandom_range(0, 99) < 3)
                    queue_drain();
            end
            wait_quiet();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end

        // Allow for any stray pixel after the last owed one.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mism_cnt == 0 && pixels_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
rtl/core/pbmr_pkg.sv
rtl/core/pbmr_front.sv
rtl/core/pbmr_queue.sv
rtl/core/pbmr_div.sv
rtl/core/pbmr_render.sv
rtl/core/power_bar_meter_renderer_core.sv
dv/tb.sv
